@@ rtl/typed_device_allocation_table_unit_macros.svh @@
// Assertion macros used by the allocation table RTL
`ifndef TYPED_DEVICE_ALLOCATION_TABLE_UNIT_MACROS_SVH
`define TYPED_DEVICE_ALLOCATION_TABLE_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define TDAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define TDAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tdat_pkg.sv @@
// Types, constants and helpers of the typed device allocation table
package tdat_pkg;

    localparam int NUM_TYPES  = 4;
    localparam int NUM_SLOTS  = 16;
    localparam int CFG_TYPES  = 4;
    localparam int TYPE_LIMIT = (NUM_TYPES < CFG_TYPES) ? NUM_TYPES : CFG_TYPES;

    localparam int ACT_W   = 1;
    localparam int JOB_W   = 8;
    localparam int TYPE_W  = 3;
    localparam int LNUM_W  = 16;
    localparam int OC_W    = 2;
    localparam int DEV_W   = 4;
    localparam int CNT_W   = 5;
    localparam int BASE_W  = 4;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 5;

    localparam int TSEL_W  = (CFG_TYPES > 1) ? $clog2(CFG_TYPES) : 1;
    localparam int POS_W   = $clog2(NUM_SLOTS);
    localparam int CMP_W   = (POS_W > BASE_W + 1) ? POS_W : BASE_W + 1;
    localparam int REL_W   = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W   = ((REL_W > CNT_W) ? REL_W : CNT_W) + 1;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(16);

    localparam logic [CNT_W-1:0]  COUNT_RESET [CFG_TYPES] = '{5'd2, 5'd3, 5'd4, 5'd1};
    localparam logic [BASE_W-1:0] BASE_RESET  [CFG_TYPES] = '{4'd0, 4'd2, 4'd5, 4'd9};

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 1'b0,
        ACT_RECLAIM = 1'b1
    } tdat_action_e;

    typedef enum logic [OC_W-1:0] {
        OC_OK        = 2'd0,
        OC_UNKNOWN   = 2'd1,
        OC_NONE_FREE = 2'd2,
        OC_JOB_NONE  = 2'd3
    } tdat_outcome_e;

    typedef enum logic [IDX_W-1:0] {
        CFG_COUNT_TYPE0 = 3'd0,
        CFG_COUNT_TYPE1 = 3'd1,
        CFG_COUNT_TYPE2 = 3'd2,
        CFG_COUNT_TYPE3 = 3'd3,
        CFG_BASE_TYPE0  = 3'd4,
        CFG_BASE_TYPE1  = 3'd5,
        CFG_BASE_TYPE2  = 3'd6,
        CFG_BASE_TYPE3  = 3'd7
    } tdat_cfg_idx_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } tdat_state_e;

    // Request fields broadcast to every cell while a scan runs
    typedef struct packed {
        tdat_action_e       action;
        logic [JOB_W-1:0]   job;
        logic [LNUM_W-1:0]  lnum;
        logic [CMP_W-1:0]   lo;
        logic [CMP_W-1:0]   hi;
    } tdat_bcast_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   pos;
        logic               found;
        logic [POS_W-1:0]   slot;
        logic [REL_W-1:0]   released;
    } tdat_carry_t;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        return (v > MAX_COUNT) ? MAX_COUNT : v;
    endfunction

endpackage

@@ rtl/tdat_if.sv @@
// Handshake channel interfaces of the allocation table
interface tdat_req_if;
    logic                         valid;
    logic                         ready;
    logic [tdat_pkg::ACT_W-1:0]   action;
    logic [tdat_pkg::JOB_W-1:0]   job_id;
    logic [tdat_pkg::TYPE_W-1:0]  device_type;
    logic [tdat_pkg::LNUM_W-1:0]  logical_number;

    modport source (output valid, action, job_id, device_type, logical_number, input ready);
    modport sink   (input valid, action, job_id, device_type, logical_number, output ready);
endinterface

interface tdat_res_if;
    logic                         valid;
    logic                         ready;
    logic [tdat_pkg::OC_W-1:0]    outcome;
    logic [tdat_pkg::DEV_W-1:0]   device_slot;
    logic [tdat_pkg::CNT_W-1:0]   released_count;
    logic [tdat_pkg::CNT_W-1:0]   free_left;

    modport source (output valid, outcome, device_slot, released_count, free_left, input ready);
    modport sink   (input valid, outcome, device_slot, released_count, free_left, output ready);
endinterface

interface tdat_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tdat_pkg::IDX_W-1:0]   index;
    logic [tdat_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tdat_cell.sv @@
// One device slot of the table and its stage of the scan chain
module tdat_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdat_pkg::tdat_bcast_t bcast,
    input  tdat_pkg::tdat_carry_t carry_in,
    output tdat_pkg::tdat_carry_t carry_out
);
    import tdat_pkg::*;

    logic              used_reg, used_next;
    logic [JOB_W-1:0]  owner_reg, owner_next;
    logic [LNUM_W-1:0] logical_reg, logical_next;
    tdat_carry_t       carry_reg, carry_next;
    logic [CMP_W-1:0]  pos_ext;
    logic              in_range;
    logic              claim;
    logic              drop;

    // Decide whether the passing token claims or frees this slot
    always_comb
    begin
        pos_ext  = CMP_W'(carry_in.pos);
        in_range = carry_in.valid && (pos_ext >= bcast.lo) && (pos_ext < bcast.hi);
        claim    = in_range && (bcast.action == ACT_ALLOC) && !used_reg && !carry_in.found;
        drop     = in_range && (bcast.action == ACT_RECLAIM) && used_reg
                   && (owner_reg == bcast.job);
    end

    // Update the slot contents
    always_comb
    begin
        used_next    = used_reg;
        owner_next   = owner_reg;
        logical_next = logical_reg;
        if (claim)
        begin
            used_next    = 1'b1;
            owner_next   = bcast.job;
            logical_next = bcast.lnum;
        end
        else if (drop)
        begin
            used_next    = 1'b0;
            owner_next   = '0;
            logical_next = '0;
        end
    end

    // Advance the token to the next slot
    always_comb
    begin
        carry_next          = carry_in;
        carry_next.pos      = carry_in.pos + POS_W'(1);
        carry_next.found    = carry_in.found || claim;
        carry_next.slot     = claim ? carry_in.pos : carry_in.slot;
        carry_next.released = carry_in.released + REL_W'(drop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            carry_reg <= carry_next;
        end
    end

    // Hold owner and logical number; no reset needed
    always_ff @(posedge clk)
    begin
        owner_reg   <= owner_next;
        logical_reg <= logical_next;
    end

    assign carry_out = carry_reg;

endmodule

@@ rtl/tdat_ctrl.sv @@
// Request sequencing, type registers, free counts and result word
module tdat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    tdat_req_if.sink              req,
    tdat_res_if.source            res,
    tdat_cfg_if.sink              cfg,
    input  tdat_pkg::tdat_carry_t chain_out,
    output tdat_pkg::tdat_carry_t chain_in,
    output tdat_pkg::tdat_bcast_t bcast
);
    import tdat_pkg::*;

    tdat_state_e        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg [CFG_TYPES];
    logic [BASE_W-1:0]  base_reg  [CFG_TYPES];
    logic [CNT_W-1:0]   free_reg  [CFG_TYPES];

    tdat_bcast_t        bcast_reg;
    logic [TSEL_W-1:0]  tsel_reg;
    logic               unknown_reg;
    logic               nofree_reg;
    logic               launch_reg;
    logic               found_reg;
    logic [POS_W-1:0]   slot_reg;
    logic [REL_W-1:0]   rel_reg;

    logic               out_valid_reg;
    tdat_outcome_e      out_outcome_reg;
    logic [DEV_W-1:0]   out_slot_reg;
    logic [CNT_W-1:0]   out_rel_reg;
    logic [CNT_W-1:0]   out_free_reg;

    logic [TSEL_W-1:0]  tsel_in;
    logic               unknown_in;
    logic               nofree_in;
    logic [CMP_W-1:0]   lo_in;
    logic [CMP_W-1:0]   hi_in;
    logic               req_fire;
    logic               scan_done;
    logic               out_free;
    logic               finish_load;
    logic               cfg_wr;

    logic [CNT_W-1:0]   free_cur;
    logic [SUM_W-1:0]   free_sum;
    tdat_outcome_e      res_outcome;
    logic [DEV_W-1:0]   res_slot;
    logic [CNT_W-1:0]   res_rel;
    logic [CNT_W-1:0]   res_free;
    logic               res_write_free;

    // Decode the incoming request
    always_comb
    begin
        tsel_in    = TSEL_W'(req.device_type);
        unknown_in = ({1'b0, req.device_type} >= (TYPE_W + 1)'(TYPE_LIMIT));
        nofree_in  = (tdat_action_e'(req.action) == ACT_ALLOC) && (free_reg[tsel_in] == '0);
        lo_in      = CMP_W'(base_reg[tsel_in]);
        hi_in      = lo_in + CMP_W'(sat_count(count_reg[tsel_in]));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = (unknown_in || nofree_in) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chain_out.valid)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshakes and result word
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        cfg.ready   = 1'b1;
        cfg_wr      = cfg.valid;
        req_fire    = (state_reg == ST_IDLE) && req.valid;
        scan_done   = (state_reg == ST_SCAN) && chain_out.valid;
        out_free    = !out_valid_reg || res.ready;
        finish_load = (state_reg == ST_FINISH) && out_free;

        free_cur       = free_reg[tsel_reg];
        free_sum       = SUM_W'(free_cur) + SUM_W'(rel_reg);
        res_outcome    = OC_OK;
        res_slot       = '0;
        res_rel        = '0;
        res_free       = free_cur;
        res_write_free = 1'b0;
        if (unknown_reg)
        begin
            res_outcome = OC_UNKNOWN;
            res_free    = '0;
        end
        else if (bcast_reg.action == ACT_ALLOC)
        begin
            if (nofree_reg || !found_reg)
                res_outcome = OC_NONE_FREE;
            else
            begin
                res_slot       = DEV_W'(slot_reg);
                res_free       = free_cur - CNT_W'(1);
                res_write_free = 1'b1;
            end
        end
        else
        begin
            if (rel_reg == '0)
                res_outcome = OC_JOB_NONE;
            else
            begin
                res_rel        = CNT_W'(rel_reg);
                res_free       = (free_sum > SUM_W'(MAX_COUNT)) ? MAX_COUNT
                                                                : CNT_W'(free_sum);
                res_write_free = 1'b1;
            end
        end
    end

    // State, type registers, free counts and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CFG_TYPES; i++)
            begin
                count_reg[i] <= COUNT_RESET[i];
                base_reg[i]  <= BASE_RESET[i];
                free_reg[i]  <= sat_count(COUNT_RESET[i]);
            end
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= req_fire && !unknown_in && !nofree_in;
            if (finish_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                case (tdat_cfg_idx_e'(cfg.index))
                    CFG_COUNT_TYPE0, CFG_COUNT_TYPE1, CFG_COUNT_TYPE2, CFG_COUNT_TYPE3:
                    begin
                        count_reg[TSEL_W'(cfg.index)] <= cfg.data[CNT_W-1:0];
                        free_reg[TSEL_W'(cfg.index)]  <= sat_count(cfg.data[CNT_W-1:0]);
                    end
                    CFG_BASE_TYPE0, CFG_BASE_TYPE1, CFG_BASE_TYPE2, CFG_BASE_TYPE3:
                        base_reg[TSEL_W'(cfg.index)] <= cfg.data[BASE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (finish_load && res_write_free)
                free_reg[tsel_reg] <= res_free;
        end
    end

    // Latch request, scan result and output word
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            bcast_reg.action <= tdat_action_e'(req.action);
            bcast_reg.job    <= req.job_id;
            bcast_reg.lnum   <= req.logical_number;
            bcast_reg.lo     <= lo_in;
            bcast_reg.hi     <= hi_in;
            tsel_reg         <= tsel_in;
            unknown_reg      <= unknown_in;
            nofree_reg       <= nofree_in;
            found_reg        <= 1'b0;
            rel_reg          <= '0;
        end
        if (scan_done)
        begin
            found_reg <= chain_out.found;
            slot_reg  <= chain_out.slot;
            rel_reg   <= chain_out.released;
        end
        if (finish_load)
        begin
            out_outcome_reg <= res_outcome;
            out_slot_reg    <= res_slot;
            out_rel_reg     <= res_rel;
            out_free_reg    <= res_free;
        end
    end

    // Drive the chain head and the broadcast
    always_comb
    begin
        chain_in       = '0;
        chain_in.valid = launch_reg;
        bcast          = bcast_reg;
    end

    assign res.valid          = out_valid_reg;
    assign res.outcome        = out_outcome_reg;
    assign res.device_slot    = out_slot_reg;
    assign res.released_count = out_rel_reg;
    assign res.free_left      = out_free_reg;

endmodule

@@ rtl/typed_device_allocation_table_unit.sv @@
// Top level of the typed device allocation table: controller and chain of slot cells
// A scan request sends a token through the slot cells, one slot cell per cycle; the result
// word is loaded once the token leaves the last cell. An unknown type or an allocate on a
// type with no free count skips the scan. A new request is accepted only once the result
// word has been loaded, and loading waits for any earlier result word to go.
// Reset: all slots free, counts, bases and free counts at reset values; no clearing pass.
`include "typed_device_allocation_table_unit_macros.svh"

module typed_device_allocation_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    tdat_req_if.sink    req,
    tdat_res_if.source  res,
    tdat_cfg_if.sink    cfg
);
    import tdat_pkg::*;

    tdat_carry_t          chain [NUM_SLOTS+1];
    tdat_bcast_t          bcast;
    logic [NUM_SLOTS:0]   tok_vld;

    tdat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg       (cfg),
        .chain_out (chain[NUM_SLOTS]),
        .chain_in  (chain[0]),
        .bcast     (bcast)
    );

    // Build the row of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        tdat_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .carry_in  (chain[g]),
            .carry_out (chain[g+1])
        );
    end

    // Collect token valid bits along the chain
    for (genvar g = 0; g <= NUM_SLOTS; g++)
    begin : g_vld
        assign tok_vld[g] = chain[g].valid;
    end

    `TDAT_ASSERT_NOW(a_single_token, 1'b1, $countones(tok_vld) <= 1, "more than one token in chain")
    `TDAT_ASSERT_NOW(a_accept_chain_empty, req.valid && req.ready, tok_vld == '0, "accept during scan")
    `TDAT_ASSERT_NEXT(a_done_blocks_input, tok_vld[NUM_SLOTS], !req.ready, "input open after scan")

endmodule
